[rtl/core/aus_pkg.sv]
package aus_pkg;

  // nal header window match, forbidden and ref_idc bits masked off
  localparam logic [31:0] TAG_MASK      = 32'hFFFFFF1F;
  localparam logic [31:0] TAG_SLICE     = 32'h00000101;
  localparam logic [31:0] TAG_IDR       = 32'h00000105;
  localparam logic [31:0] TAG_SPS       = 32'h00000107;
  localparam logic [31:0] TAG_PPS       = 32'h00000108;
  localparam logic [31:0] TAG_AUD       = 32'h00000109;
  localparam logic [31:0] WINDOW_RESET  = 32'hFFFFFFFF;
  localparam logic [31:0] MB_SATURATED  = 32'hFFFFFFFF;
  localparam logic [19:0] LIMIT_RESET   = 20'h80000;
  localparam logic [19:0] LIMIT_FLOOR   = 20'd16;
  localparam logic [19:0] LIMIT_CEIL    = 20'hFFFFC;
  localparam logic [19:0] START_BYTES   = 20'd4;

  typedef enum logic [1:0] {
    CUT_SLICE = 2'd0,
    CUT_PARAM = 2'd1,
    CUT_SIZE  = 2'd2,
    CUT_END   = 2'd3
  } cut_reason_t;

  typedef struct packed {
    logic [19:0] len;
    cut_reason_t reason;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] window;
    logic [19:0] count;
    logic        start_seen;
    logic [31:0] prev_mb;
    logic [31:0] la_word;
    logic [2:0]  la_fill;
    logic [5:0]  la_zeros;
  } state_t;

  localparam state_t STATE_RESET = '{
    window:     WINDOW_RESET,
    count:      20'd0,
    start_seen: 1'b0,
    prev_mb:    32'd0,
    la_word:    32'd0,
    la_fill:    3'd0,
    la_zeros:   6'd0
  };

  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } step_res_t;

  // leading zeros of one byte, 8 when the byte is zero
  function automatic logic [3:0] lzc8(input logic [7:0] v);
    logic [3:0] z;
    casez (v)
      8'b1???????: z = 4'd0;
      8'b01??????: z = 4'd1;
      8'b001?????: z = 4'd2;
      8'b0001????: z = 4'd3;
      8'b00001???: z = 4'd4;
      8'b000001??: z = 4'd5;
      8'b0000001?: z = 4'd6;
      8'b00000001: z = 4'd7;
      default:     z = 4'd8;
    endcase
    return z;
  endfunction

endpackage

[rtl/core/h264_access_unit_splitter.sv]
// h.264 annex b access unit splitter. bytes of an annex b buffer come in one
// per transfer on the slave side (tlast marks the last byte of the buffer);
// the block watches for a start code and nal header, decodes
// first_mb_in_slice from the four bytes after a slice header, and reports
// one length per closed access unit on the master side: tdata carries the
// length, tuser the cut reason (slice restart, parameter set or delimiter,
// size limit, buffer remainder) and tlast marks the last result caused by
// one input byte. lengths of start-code cuts stop before the 00 00 01.
// the size limit register is clamped to 16..min(MAX_AU_BYTES, 0xffffc) and
// should be written only while no byte is in flight. rate: one byte per
// clock; a byte is registered at the input and then pushed into the result
// fifo. the single result port is the limit, so a byte that closes a unit
// at buffer end gives two results, which leave one at a time. the input is
// held while the 4-entry result fifo has fewer than two free entries.
module h264_access_unit_splitter #(
  parameter int MAX_AU_BYTES = 524288
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: au_size_limit
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  // input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  logic        s_tlast,   // buffer_end
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [19:0] au_length, [23:20] zero
  output logic [1:0]  m_tuser,   // [1:0] cut_reason
  output logic        m_tlast    // final_result
);
  import aus_pkg::*;

  // effective upper bound of the limit register
  localparam int LimCap = (MAX_AU_BYTES < 32'hFFFFC) ? MAX_AU_BYTES : 32'hFFFFC;

  logic [19:0] size_limit;
  logic [19:0] limit_eff;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;

  state_t      state, state_next;
  step_res_t   step_res;
  result_t     head;
  logic        fifo_not_empty, fifo_room;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      size_limit <= cfg_wr_data;
    end
  end

  always_comb begin
    if (size_limit < LIMIT_FLOOR) begin
      limit_eff = LIMIT_FLOOR;
    end else if ({12'd0, size_limit} > LimCap) begin
      limit_eff = 20'(LimCap);
    end else begin
      limit_eff = size_limit;
    end
  end

  // a byte moves into the step logic only when two results would fit
  assign advance  = in_valid && fifo_room;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  aus_step u_step (
    .cur     (state),
    .byte_in (in_byte),
    .last_in (in_last),
    .limit   (limit_eff),
    .nxt     (state_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  assign pop = m_tvalid && m_tready;

  aus_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_num     (advance ? step_res.num : 2'd0),
    .push0        (step_res.res0),
    .push1        (step_res.res1),
    .pop          (pop),
    .head         (head),
    .not_empty    (fifo_not_empty),
    .room_for_two (fifo_room)
  );

  assign m_tvalid = fifo_not_empty;
  assign m_tdata  = {4'd0, head.len};
  assign m_tuser  = head.reason;
  assign m_tlast  = head.last;

endmodule

[rtl/core/aus_step.sv]
module aus_step (
  input  aus_pkg::state_t    cur,
  input  logic [7:0]         byte_in,
  input  logic               last_in,
  input  logic [19:0]        limit,
  output aus_pkg::state_t    nxt,
  output aus_pkg::step_res_t res
);
  import aus_pkg::*;

  logic [31:0] tag;
  logic        slice_tag, param_tag, pend, decide, slice_cut, size_cut, param_cut;
  logic [20:0] c0, c1, c2, c3, at;
  logic        seen1;
  logic [31:0] prev1, base_word, byte_word, law1, shl, mb;
  logic [2:0]  base_fill, fill1;
  logic [5:0]  base_zeros, zeros1;
  logic [19:0] param_len, slice_len;
  result_t     first;

  always_comb begin
    tag       = cur.window & TAG_MASK;
    slice_tag = (cur.la_fill == 3'd0) && ((tag == TAG_SLICE) || (tag == TAG_IDR));
    param_tag = (cur.la_fill == 3'd0) &&
                ((tag == TAG_SPS) || (tag == TAG_PPS) || (tag == TAG_AUD));

    // parameter set or delimiter closes the open unit before the start code
    param_cut = param_tag && cur.start_seen;
    param_len = (cur.count >= START_BYTES) ? cur.count - START_BYTES : 20'd0;
    c0        = param_cut ? {1'b0, START_BYTES} : {1'b0, cur.count};
    seen1     = param_tag ? 1'b1 : cur.start_seen;
    prev1     = param_tag ? 32'd0 : cur.prev_mb;
    c1        = c0 + 21'd1;

    // slice header lookahead, left aligned, leading zeros tracked per byte
    pend       = slice_tag || (cur.la_fill != 3'd0);
    base_word  = slice_tag ? 32'd0 : cur.la_word;
    base_fill  = slice_tag ? 3'd0 : cur.la_fill;
    base_zeros = slice_tag ? 6'd0 : cur.la_zeros;
    case (base_fill[1:0])
      2'd0:    byte_word = {byte_in, 24'd0};
      2'd1:    byte_word = {8'd0, byte_in, 16'd0};
      2'd2:    byte_word = {16'd0, byte_in, 8'd0};
      default: byte_word = {24'd0, byte_in};
    endcase
    law1   = base_word | byte_word;
    fill1  = base_fill + 3'd1;
    zeros1 = (base_zeros == {1'b0, base_fill[1:0], 3'b000}) ?
             base_zeros + {2'b00, lzc8(byte_in)} : base_zeros;

    // exp-golomb first_mb_in_slice
    shl = law1 << zeros1[4:0];
    mb  = (law1 == 32'd0) ? MB_SATURATED :
          (shl >> (5'd31 - zeros1[4:0])) - 32'd1;

    decide    = pend && ((fill1 >= 3'd4) || last_in);
    slice_cut = decide && seen1 && (mb <= prev1);
    at        = c1 - {18'd0, fill1};
    slice_len = (at >= 21'd4) ? at[19:0] - START_BYTES : 20'd0;

    nxt.window = {cur.window[23:0], byte_in};
    if (decide) begin
      c2             = slice_cut ? 21'd4 + {18'd0, fill1} : c1;
      nxt.start_seen = 1'b1;
      nxt.prev_mb    = mb;
      nxt.la_word    = 32'd0;
      nxt.la_fill    = 3'd0;
      nxt.la_zeros   = 6'd0;
    end else begin
      c2             = c1;
      nxt.start_seen = seen1;
      nxt.prev_mb    = prev1;
      nxt.la_word    = pend ? law1 : cur.la_word;
      nxt.la_fill    = pend ? fill1 : cur.la_fill;
      nxt.la_zeros   = pend ? zeros1 : cur.la_zeros;
    end

    // size limit, held off while a slice header is pending
    size_cut = (nxt.la_fill == 3'd0) && (c2 >= {1'b0, limit});
    if (size_cut) begin
      c3             = c2 - {1'b0, limit - START_BYTES};
      nxt.start_seen = 1'b0;
      nxt.prev_mb    = 32'd0;
    end else begin
      c3 = c2;
    end
    nxt.count = c3[19:0];

    if (last_in) begin
      nxt = STATE_RESET;
    end

    // cuts exclude each other; only the buffer end can follow one
    if (param_cut) begin
      first = '{len: param_len, reason: CUT_PARAM, last: !last_in};
    end else if (slice_cut) begin
      first = '{len: slice_len, reason: CUT_SLICE, last: !last_in};
    end else if (size_cut) begin
      first = '{len: limit - START_BYTES, reason: CUT_SIZE, last: !last_in};
    end else begin
      first = '{len: c3[19:0], reason: CUT_END, last: 1'b1};
    end
    res.res1 = '{len: c3[19:0], reason: CUT_END, last: 1'b1};
    res.res0 = first;
    if (param_cut || slice_cut || size_cut) begin
      res.num = last_in ? 2'd2 : 2'd1;
    end else begin
      res.num = last_in ? 2'd1 : 2'd0;
    end
  end

endmodule

[rtl/core/aus_result_fifo.sv]
module aus_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_num,
  input  aus_pkg::result_t  push0,
  input  aus_pkg::result_t  push1,
  input  logic              pop,
  output aus_pkg::result_t  head,
  output logic              not_empty,
  output logic              room_for_two
);
  import aus_pkg::*;

  localparam int Depth = 4;

  result_t      mem [Depth];
  logic [1:0]   wr_ptr, rd_ptr;
  logic [2:0]   count;
  logic [2:0]   count_next;

  assign head         = mem[rd_ptr];
  assign not_empty    = (count != 3'd0);
  assign room_for_two = (count <= 3'(Depth - 2));
  assign count_next   = count + {1'b0, push_num} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_num == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_num;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule

[tb/h264_access_unit_splitter_test.sv]
import aus_pkg::*;

// tracks the open access unit the same way the splitter does and keeps the
// cuts that the accepted bytes must produce, oldest first
class au_cut_tracker;
  int unsigned size_cap;
  logic [19:0] size_limit;
  logic [31:0] window;
  int unsigned au_count;
  bit          start_seen;
  logic [31:0] prev_mb;
  logic [31:0] la_word;
  int unsigned la_fill;
  result_t     expected_cuts[$];
  int unsigned mismatches;
  int unsigned reason_hits[4];

  function new(int unsigned cap);
    size_cap = cap;
    size_limit = LIMIT_RESET;
    mismatches = 0;
    foreach (reason_hits[i]) reason_hits[i] = 0;
    clear();
  endfunction

  function void clear();
    window = WINDOW_RESET;
    au_count = 0;
    start_seen = 0;
    prev_mb = 0;
    la_word = 0;
    la_fill = 0;
  endfunction

  function int unsigned effective_limit();
    int unsigned l;
    l = size_limit;
    if (l < LIMIT_FLOOR) l = LIMIT_FLOOR;
    if (l > size_cap) l = size_cap;
    if (l > LIMIT_CEIL) l = LIMIT_CEIL;
    return l;
  endfunction

  // exp-golomb ue(v) over a left-aligned word, all zeros saturates
  function logic [31:0] first_mb(logic [31:0] w);
    int unsigned z;
    z = 0;
    if (w == 0) return MB_SATURATED;
    while (!w[31]) begin
      w = w << 1;
      z++;
    end
    return (w >> (31 - z)) - 1;
  endfunction

  function result_t make_cut(int unsigned len, cut_reason_t why);
    result_t r;
    r.len = len[19:0];
    r.reason = why;
    r.last = 1'b0;
    return r;
  endfunction

  // one accepted byte
  function void note_byte(logic [7:0] b, logic buf_end);
    logic [31:0] tag;
    logic [31:0] mb;
    int unsigned lim;
    int unsigned at;
    bit          slice_start;
    result_t     step_cuts[$];
    tag = window & TAG_MASK;
    lim = effective_limit();
    slice_start = 0;
    if (la_fill == 0) begin
      if (tag == TAG_SLICE || tag == TAG_IDR) begin
        slice_start = 1;
        la_word = 0;
      end else if (tag == TAG_SPS || tag == TAG_PPS || tag == TAG_AUD) begin
        if (start_seen) begin
          step_cuts.push_back(make_cut(au_count >= 4 ? au_count - 4 : 0, CUT_PARAM));
          au_count = 4;
        end
        start_seen = 1;
        prev_mb = 0;
      end
    end
    window = {window[23:0], b};
    au_count++;
    if (slice_start || la_fill > 0) begin
      la_word |= 32'(b) << (24 - 8 * (la_fill % 4));
      la_fill++;
    end
    if (la_fill > 0 && (la_fill >= 4 || buf_end)) begin
      mb = first_mb(la_word);
      if (start_seen && mb <= prev_mb) begin
        at = au_count - la_fill;
        step_cuts.push_back(make_cut(at >= 4 ? at - 4 : 0, CUT_SLICE));
        au_count = 4 + la_fill;
      end
      start_seen = 1;
      prev_mb = mb;
      la_fill = 0;
      la_word = 0;
    end
    if (la_fill == 0 && au_count >= lim) begin
      step_cuts.push_back(make_cut(lim - 4, CUT_SIZE));
      au_count -= lim - 4;
      start_seen = 0;
      prev_mb = 0;
    end
    if (buf_end) begin
      step_cuts.push_back(make_cut(au_count, CUT_END));
      clear();
    end
    if (step_cuts.size() > 0) step_cuts[step_cuts.size() - 1].last = 1'b1;
    foreach (step_cuts[i]) expected_cuts.push_back(step_cuts[i]);
  endfunction

  // one accepted result
  function void check_cut(logic [23:0] data, logic [1:0] why, logic fin);
    result_t e;
    if (expected_cuts.size() == 0) begin
      $display("%0t: unexpected cut len %0d reason %0d last %0b", $time, data, why, fin);
      mismatches++;
      return;
    end
    e = expected_cuts.pop_front();
    reason_hits[e.reason]++;
    if (data !== {4'b0, e.len}) begin
      $display("%0t: au_length expected %0d got %0d", $time, e.len, data);
      mismatches++;
    end
    if (why !== e.reason) begin
      $display("%0t: cut_reason expected %0d got %0d", $time, e.reason, why);
      mismatches++;
    end
    if (fin !== e.last) begin
      $display("%0t: final_result expected %0b got %0b", $time, e.last, fin);
      mismatches++;
    end
  endfunction
endclass

module h264_access_unit_splitter_test;

  localparam int unsigned AU_BYTES_CAP = 524288;
  localparam int unsigned QUIET_LIMIT = 4000;   // cycles with no transfer at all
  localparam int unsigned HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 8;    // pipeline drain after last result
  localparam int unsigned PHASE_BYTES = 160;
  localparam int unsigned PHASES = 8;

  // short hand-built stream, written with the limit at its floor
  localparam logic [8:0] DIRECTED [26] = '{
    9'h000, 9'h000, 9'h001, 9'h009,           // delimiter opens the first unit
    9'h0F0,
    9'h000, 9'h000, 9'h001, 9'h065,           // idr slice, first_mb 0
    9'h088, 9'h0FF, 9'h000, 9'h000,
    9'h000, 9'h000, 9'h001, 9'h041,           // slice with an all-zero code word
    9'h000, 9'h000, 9'h000, 9'h000,
    9'h000, 9'h000, 9'h001, 9'h0E1,           // forbidden bit set, type 1
    9'h100                                    // buffer ends inside the lookahead
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [19:0] cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  au_cut_tracker tracker = new(AU_BYTES_CAP);

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_request = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned buffers_sent = 0;
  int unsigned gen_mb = 0;
  logic [8:0]  buffer_bytes[$];   // {buffer_end, stream_byte}

  h264_access_unit_splitter #(
    .MAX_AU_BYTES(AU_BYTES_CAP)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // every result transfer goes to the tracker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_cut(m_tdata, m_tuser, m_tlast);
  end

  // watchdog on cycles where neither side moves a transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d cuts outstanding", $time,
                 quiet_cycles, tracker.expected_cuts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // register write, only while nothing is in flight
  task automatic set_limit(input logic [19:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    tracker.size_limit = v;
    cfg_wr_en <= 1'b0;
  endtask

  // one byte transfer with random sender gaps in front of it
  task automatic send_byte(input logic [7:0] b, input logic buf_end);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= buf_end;
    do @(posedge clk); while (!s_tready);
    tracker.note_byte(b, buf_end);
    bytes_sent++;
  endtask

  // stop offering bytes until every predicted cut has come out
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (tracker.expected_cuts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // slice lookahead word: mostly a first_mb that climbs and sometimes restarts,
  // otherwise a random code word with any number of leading zeros
  function automatic logic [31:0] slice_word();
    int unsigned nbits;
    int unsigned code;
    int unsigned rz;
    int unsigned shift;
    if ($urandom_range(4) == 0) begin
      rz = $urandom_range(32);
      return (rz == 32) ? 32'h0 : ((32'h80000000 | $urandom) >> rz);
    end
    if ($urandom_range(3) == 0 || gen_mb > 5000) gen_mb = 0;
    else gen_mb += $urandom_range(1, 40);
    code = gen_mb + 1;
    nbits = $clog2(code + 1);
    shift = 33 - 2 * nbits;
    return (code << shift) | ($urandom & ((32'h1 << shift) - 1));
  endfunction

  function automatic logic [7:0] payload_byte();
    return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  // one annex b buffer: a few nal units, occasional noise, sometimes cut
  // short in the middle of a slice lookahead
  task automatic build_buffer();
    int unsigned nal_count;
    int unsigned kind;
    int unsigned pay;
    int unsigned keep;
    logic [4:0]  nal_type;
    logic [31:0] word;
    logic [8:0]  tail;
    buffer_bytes.delete();
    nal_count = $urandom_range(1, 6);
    for (int i = 0; i < nal_count; i++) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8)) buffer_bytes.push_back({1'b0, payload_byte()});
      end
      if ($urandom_range(1)) buffer_bytes.push_back(9'h000);
      buffer_bytes.push_back(9'h000);
      buffer_bytes.push_back(9'h000);
      buffer_bytes.push_back(9'h001);
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3: nal_type = 5'd1;
        4, 5:       nal_type = 5'd5;
        6:          nal_type = 5'd7;
        7:          nal_type = 5'd8;
        8:          nal_type = 5'd9;
        default:    nal_type = 5'($urandom);
      endcase
      buffer_bytes.push_back({1'b0, 3'($urandom), nal_type});
      if (nal_type == 5'd1 || nal_type == 5'd5) begin
        word = slice_word();
        if (i == nal_count - 1 && $urandom_range(4) == 0) begin
          keep = $urandom_range(3);
          for (int k = 0; k < keep; k++) buffer_bytes.push_back({1'b0, word[31 - 8 * k -: 8]});
          break;
        end
        for (int k = 0; k < 4; k++) buffer_bytes.push_back({1'b0, word[31 - 8 * k -: 8]});
      end
      pay = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(12);
      repeat (pay) buffer_bytes.push_back({1'b0, payload_byte()});
    end
    tail = buffer_bytes.pop_back();
    buffer_bytes.push_back({1'b1, tail[7:0]});
  endtask

  initial begin
    int unsigned phase_sent;
    logic [19:0] phase_limit;
    bit          held;
    bit          paused;

    held = 0;
    paused = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed stream with the smallest limit, no idling
    set_limit(LIMIT_FLOOR);
    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    buffers_sent++;
    wait_for_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_limit = 20'hFFFFF;                  // above the cap
        1:       phase_limit = LIMIT_FLOOR;
        2:       phase_limit = 20'd0;                      // below the floor
        3:       phase_limit = 20'($urandom_range(17, 64));
        4:       phase_limit = 20'(AU_BYTES_CAP);
        5:       phase_limit = 20'd40;
        6:       phase_limit = 20'($urandom_range(16, 300));
        default: phase_limit = 20'd17;
      endcase
      set_limit(phase_limit);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        build_buffer();
        foreach (buffer_bytes[i]) send_byte(buffer_bytes[i][7:0], buffer_bytes[i][8]);
        phase_sent += buffer_bytes.size();
        buffers_sent++;
        // long hold-off on the result side while bytes keep coming
        if (p == 2 && !held && phase_sent > PHASE_BYTES / 3) begin
          held = 1;
          hold_request = 1;
        end
        // sender pause mid-phase until the pipeline is empty
        if (p == 5 && !paused && phase_sent > PHASE_BYTES / 2) begin
          paused = 1;
          wait_for_results();
        end
      end
      wait_for_results();
    end

    $display("sent %0d bytes in %0d buffers over %0d limit settings and four idle mixes",
             bytes_sent, buffers_sent, PHASES + 1);
    $display("cuts seen: slice %0d, parameter set %0d, size %0d, buffer end %0d",
             tracker.reason_hits[CUT_SLICE], tracker.reason_hits[CUT_PARAM],
             tracker.reason_hits[CUT_SIZE], tracker.reason_hits[CUT_END]);
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/aus_pkg.sv
rtl/core/aus_step.sv
rtl/core/aus_result_fifo.sv
rtl/core/h264_access_unit_splitter.sv
tb/h264_access_unit_splitter_test.sv
